>>> hdl/sexpr_definition_tokenizer_defines.svh
// assertion macros shared by the tokenizer modules
`ifndef SEXPR_DEFINITION_TOKENIZER_DEFINES_SVH
`define SEXPR_DEFINITION_TOKENIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, checked outside reset
`define SDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

>>> hdl/sdt_pkg.sv
// types, character constants and helpers of the definition tokenizer
package sdt_pkg;

    // lexer mode
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_QUOTE   = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_ERROR   = 3'd4
    } t_mode;

    // result kind
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    // most results one byte can cause
    localparam logic [1:0] RES_MAX = 2'd3;

    // character codes
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_HYPHEN    = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // one result
    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
    } t_result;

    // all results of one input byte, oldest in slot 0
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     slot;
    } t_bundle;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) ||
               (c == CH_HYPHEN) || (c == CH_UNDERSCORE) || (c == CH_HASH);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_NEWLINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // append one result, dropping anything past the limit
    function automatic t_bundle bundle_add(input t_bundle b, input t_kind k,
                                           input logic [7:0] c);
        t_bundle r;
        r = b;
        if (b.count < RES_MAX) begin
            r.slot[b.count].kind = k;
            r.slot[b.count].chr  = (k == KIND_BYTE) ? c : 8'h00;
            r.count              = 2'(b.count + 2'd1);
        end
        return r;
    endfunction

endpackage

>>> hdl/sexpr_definition_tokenizer.sv
// top level of the definition-file tokenizer
// Accepts one source byte per cycle while full is low and writes its token
// results (token byte, token end, syntax error, abort) through a queue-style
// output, one per cycle while pop is high; a byte causes 0 to 3 results, and
// bytes that cause none never enter the queue. Between the classifier and the
// result stage sits a queue of QUEUE_DEPTH result bundles, so input keeps
// flowing while results wait; full rises only when that queue is full, and the
// sustained rate is one byte per cycle as long as bytes average at most one
// result each. Results pass the queue storage and then the output register.
module sexpr_definition_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_in,
    input  logic       i_stream_end,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_char_out,
    output logic       o_run_last
);
    import sdt_pkg::*;

    t_bundle q_in, q_head;
    logic    q_push, q_pop, q_empty, q_full;

    // byte classification and mode tracking
    sdt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_char_in    (i_char_in),
        .i_stream_end (i_stream_end),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_bundle     (q_in)
    );

    // bundle queue
    sdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // result output stage
    sdt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_kind     (o_kind),
        .o_char_out (o_char_out),
        .o_run_last (o_run_last)
    );

    assign full = q_full;

endmodule

>>> hdl/sdt_front.sv
// front end: classifies each byte, tracks the lexer mode, builds result bundles
`include "sexpr_definition_tokenizer_defines.svh"

module sdt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_char_in,
    input  logic             i_stream_end,
    input  logic             i_q_full,
    output logic             o_q_push,
    output sdt_pkg::t_bundle o_bundle
);
    import sdt_pkg::*;

    t_mode   r_mode, n_mode;
    logic    r_esc, n_esc;
    t_bundle bnd;
    logic    run_idle;
    logic    accept;

    assign accept = i_push && !i_q_full;

    // next mode and results of the current byte
    always_comb begin
        n_mode   = r_mode;
        n_esc    = r_esc;
        bnd      = '0;
        run_idle = 1'b0;
        case (r_mode)
            MODE_IDLE: begin
                run_idle = 1'b1;
            end
            MODE_QUOTE: begin
                if (i_char_in == CH_NEWLINE) begin
                    n_mode = MODE_ERROR;
                    n_esc  = 1'b0;
                    bnd    = bundle_add(bnd, KIND_ERROR, 8'h00);
                end else if (i_char_in == CH_DQUOTE) begin
                    bnd = bundle_add(bnd, KIND_BYTE, i_char_in);
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else begin
                        bnd    = bundle_add(bnd, KIND_END, 8'h00);
                        n_mode = MODE_IDLE;
                    end
                end else if (i_char_in == CH_BACKSLASH) begin
                    n_esc = !r_esc;
                    bnd   = bundle_add(bnd, KIND_BYTE, i_char_in);
                end else begin
                    n_esc = 1'b0;
                    bnd   = bundle_add(bnd, KIND_BYTE, i_char_in);
                end
            end
            MODE_WORD: begin
                if (is_word_char(i_char_in)) begin
                    bnd = bundle_add(bnd, KIND_BYTE, i_char_in);
                end else if (is_blank(i_char_in)) begin
                    bnd    = bundle_add(bnd, KIND_END, 8'h00);
                    n_mode = MODE_IDLE;
                end else if (is_single(i_char_in) || (i_char_in == CH_SEMICOLON) ||
                             (i_char_in == CH_DQUOTE)) begin
                    // the delimiter closes the word and is then lexed from idle
                    bnd      = bundle_add(bnd, KIND_END, 8'h00);
                    n_mode   = MODE_IDLE;
                    run_idle = 1'b1;
                end else begin
                    n_mode = MODE_ERROR;
                    bnd    = bundle_add(bnd, KIND_ERROR, 8'h00);
                end
            end
            MODE_COMMENT: begin
                if (i_char_in == CH_NEWLINE) begin
                    n_mode   = MODE_IDLE;
                    run_idle = 1'b1;
                end
            end
            default: begin
                // error mode swallows everything
            end
        endcase

        // byte seen from idle
        if (run_idle) begin
            if (is_single(i_char_in)) begin
                bnd = bundle_add(bnd, KIND_BYTE, i_char_in);
                bnd = bundle_add(bnd, KIND_END, 8'h00);
            end else if (i_char_in == CH_SEMICOLON) begin
                n_mode = MODE_COMMENT;
            end else if (i_char_in == CH_DQUOTE) begin
                n_mode = MODE_QUOTE;
                n_esc  = 1'b0;
                bnd    = bundle_add(bnd, KIND_BYTE, i_char_in);
            end else if (is_word_char(i_char_in)) begin
                n_mode = MODE_WORD;
                bnd    = bundle_add(bnd, KIND_BYTE, i_char_in);
            end else if (!is_blank(i_char_in)) begin
                n_mode = MODE_ERROR;
                bnd    = bundle_add(bnd, KIND_ERROR, 8'h00);
            end
        end

        // stream end aborts an open token and returns to idle
        if (i_stream_end) begin
            if ((n_mode == MODE_WORD) || (n_mode == MODE_QUOTE)) begin
                bnd = bundle_add(bnd, KIND_ABORT, 8'h00);
            end
            n_mode = MODE_IDLE;
            n_esc  = 1'b0;
        end
    end

    // mode registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_esc  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
        end
    end

    // only bytes that cause results enter the queue
    assign o_q_push = accept && (bnd.count != 2'd0);
    assign o_bundle = bnd;

    `SDT_ASSERT_NOW(a_esc_in_quote, i_clk, i_rst_n, r_esc, r_mode == MODE_QUOTE)
    `SDT_ASSERT_NOW(a_error_silent, i_clk, i_rst_n,
        accept && (r_mode == MODE_ERROR) && !i_stream_end, !o_q_push)
    `SDT_ASSERT_NEXT(a_end_to_idle, i_clk, i_rst_n,
        accept && i_stream_end, (r_mode == MODE_IDLE) && !r_esc)

endmodule

>>> hdl/sdt_queue.sv
// short queue of result bundles between front and back end
module sdt_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sdt_pkg::t_bundle i_data,
    input  logic             i_pop,
    output sdt_pkg::t_bundle o_head,
    output logic             o_empty,
    output logic             o_full
);
    import sdt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : PW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : PW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);

endmodule

>>> hdl/sdt_back.sv
// back end: hands out the results of each bundle one per transfer
`include "sexpr_definition_tokenizer_defines.svh"

module sdt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sdt_pkg::t_bundle i_head,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_char_out,
    output logic             o_run_last
);
    import sdt_pkg::*;

    logic       r_out_valid;
    t_result    r_out;
    logic       r_out_last;
    logic [1:0] r_idx;
    logic       load, take, slot_last;

    // output register is free when empty or being taken
    assign load      = !r_out_valid || i_pop;
    assign take      = load && !i_q_empty;
    assign slot_last = (r_idx == 2'(i_head.count - 2'd1));
    assign o_q_pop   = take && slot_last;

    // slot index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_idx <= slot_last ? 2'd0 : 2'(r_idx + 2'd1);
            end
            if (load) begin
                r_out_valid <= take;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out      <= i_head.slot[r_idx];
            r_out_last <= slot_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_char_out = r_out.chr;
    assign o_run_last = r_out_last;

    `SDT_ASSERT_NOW(a_idx_in_bundle, i_clk, i_rst_n, !i_q_empty, r_idx < i_head.count)
    `SDT_ASSERT_NOW(a_char_only_bytes, i_clk, i_rst_n,
        r_out_valid && (r_out.kind != KIND_BYTE), r_out.chr == 8'h00)

endmodule

>>> tb/tb.sv
// self-checking testbench for the definition-file tokenizer
module tb;
    import sdt_pkg::*;

    // one predicted token result
    typedef struct {
        t_kind      kind;
        logic [7:0] chr;
        logic       last;
    } t_token_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_char_in = 8'h00;
    logic       i_stream_end = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_char_out;
    logic       o_run_last;

    // predictor state
    t_mode         lex_mode = MODE_IDLE;
    logic          esc_open = 1'b0;
    t_token_result byte_results[$];
    t_token_result token_stream_q[$];

    int mismatch_count = 0;
    int bytes_sent = 0;
    bit calm = 1'b0;
    int hold_left = 0;

    sexpr_definition_tokenizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_in   (i_char_in),
        .i_stream_end(i_stream_end),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (o_kind),
        .o_char_out  (o_char_out),
        .o_run_last  (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // character classes
    function automatic bit word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               c == CH_HYPHEN || c == CH_UNDERSCORE || c == CH_HASH;
    endfunction

    function automatic bit lone_char(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_APOS || c == CH_NEWLINE;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    // add one result for the current byte, at most three per byte
    task automatic add_result(input t_kind k, input logic [7:0] c);
        t_token_result r;
        if (byte_results.size() < 3) begin
            r.kind = k;
            r.chr  = (k == KIND_BYTE) ? c : 8'h00;
            r.last = 1'b0;
            byte_results = {byte_results, r};
        end
    endtask

    // a byte seen while no token is open
    task automatic lex_idle(input logic [7:0] c);
        if (lone_char(c)) begin
            add_result(KIND_BYTE, c);
            add_result(KIND_END, 8'h00);
        end else if (c == CH_SEMICOLON) begin
            lex_mode = MODE_COMMENT;
        end else if (c == CH_DQUOTE) begin
            lex_mode = MODE_QUOTE;
            esc_open = 1'b0;
            add_result(KIND_BYTE, c);
        end else if (word_char(c)) begin
            lex_mode = MODE_WORD;
            add_result(KIND_BYTE, c);
        end else if (!blank_char(c)) begin
            lex_mode = MODE_ERROR;
            add_result(KIND_ERROR, 8'h00);
        end
    endtask

    // predict the token results of one accepted byte
    task automatic lex_byte(input logic [7:0] c, input logic last);
        byte_results = {};
        case (lex_mode)
            MODE_IDLE: lex_idle(c);
            MODE_QUOTE: begin
                if (c == CH_NEWLINE) begin
                    lex_mode = MODE_ERROR;
                    esc_open = 1'b0;
                    add_result(KIND_ERROR, 8'h00);
                end else if (c == CH_DQUOTE) begin
                    add_result(KIND_BYTE, c);
                    if (esc_open) begin
                        esc_open = 1'b0;
                    end else begin
                        add_result(KIND_END, 8'h00);
                        lex_mode = MODE_IDLE;
                    end
                end else if (c == CH_BACKSLASH) begin
                    esc_open = ~esc_open;
                    add_result(KIND_BYTE, c);
                end else begin
                    esc_open = 1'b0;
                    add_result(KIND_BYTE, c);
                end
            end
            MODE_WORD: begin
                if (word_char(c)) begin
                    add_result(KIND_BYTE, c);
                end else if (blank_char(c)) begin
                    add_result(KIND_END, 8'h00);
                    lex_mode = MODE_IDLE;
                end else if (lone_char(c) || c == CH_SEMICOLON || c == CH_DQUOTE) begin
                    // the delimiter starts whatever follows
                    add_result(KIND_END, 8'h00);
                    lex_mode = MODE_IDLE;
                    lex_idle(c);
                end else begin
                    lex_mode = MODE_ERROR;
                    add_result(KIND_ERROR, 8'h00);
                end
            end
            MODE_COMMENT: begin
                if (c == CH_NEWLINE) begin
                    lex_mode = MODE_IDLE;
                    lex_idle(c);
                end
            end
            default: ;
        endcase
        if (last) begin
            if (lex_mode == MODE_WORD || lex_mode == MODE_QUOTE)
                add_result(KIND_ABORT, 8'h00);
            lex_mode = MODE_IDLE;
            esc_open = 1'b0;
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i])
            token_stream_q = {token_stream_q, byte_results[i]};
    endtask

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // send one byte, with an optional gap before it
    task automatic send_byte(input logic [7:0] c, input logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_char_in    <= c;
        i_stream_end <= last;
        do @(posedge i_clk); while (full !== 1'b0);
        lex_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit end_on_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_on_last && i == s.len() - 1);
    endtask

    // result side stalls in bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 4);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_token_result head;
        if (i_rst_n && pop && !empty) begin
            if (token_stream_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d char=%02h last=%0b",
                                          o_kind, o_char_out, o_run_last));
            end else begin
                head = token_stream_q.pop_front();
                if (o_kind !== head.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_kind, head.kind));
                if (o_char_out !== head.chr)
                    report_mismatch($sformatf("char %02h, want %02h", o_char_out, head.chr));
                if (o_run_last !== head.last)
                    report_mismatch($sformatf("run_last %0b, want %0b",
                                              o_run_last, head.last));
            end
        end
    end

    task automatic test_single_tokens();
        send_text("()'\n\t ", 0);
    endtask

    // word closed by a semicolon, then a comment up to newline
    task automatic test_words_and_comments();
        send_text("a-Z_#;c\n", 0);
    endtask

    // escaped quote, then a cancelled backslash pair before the close
    task automatic test_strings();
        send_text("\"\\\"\\\\\"", 0);
    endtask

    task automatic test_errors();
        // stray byte in idle, then ignored until the stream ends
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // stray byte inside a word, ending the stream
        send_byte("k", 1'b0);
        send_byte(8'hFF, 1'b1);
        // newline inside quotes
        send_text("\"\n", 1);
    endtask

    task automatic test_stream_end();
        // open word aborted
        send_text("g", 1);
        // word closed by a quote at stream end: the quote opens a string that is aborted
        send_text("w\"", 1);
        // open comment ends silently
        send_text(";", 1);
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 4))
            0: return CH_HYPHEN;
            1: return CH_UNDERSCORE;
            2: return CH_HASH;
            3: return 8'(8'h41 + $urandom_range(0, 25));
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // well-formed token sequences with some noise, until count bytes are sent
    task automatic test_random_tokens(input int count);
        logic [7:0] txt[$];
        int         stop_at;
        int         sel;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            txt = {};
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 9: begin
                    repeat ($urandom_range(1, 6)) txt = {txt, rand_word_char()};
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0: txt = {txt, CH_LPAREN};
                        1: txt = {txt, CH_RPAREN};
                        2: txt = {txt, CH_APOS};
                        default: txt = {txt, CH_NEWLINE};
                    endcase
                end
                4: txt = {txt, ($urandom_range(0, 1) ? CH_SPACE : CH_TAB)};
                5, 6: begin
                    txt = {txt, CH_DQUOTE};
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 3))
                            0: txt = {txt, CH_BACKSLASH};
                            1: txt = {txt, rand_word_char()};
                            default: txt = {txt, 8'($urandom_range(0, 255))};
                        endcase
                    end
                    txt = {txt, CH_DQUOTE};
                end
                7: begin
                    txt = {txt, CH_SEMICOLON};
                    repeat ($urandom_range(0, 5)) txt = {txt, 8'($urandom_range(0, 255))};
                    txt = {txt, CH_NEWLINE};
                end
                default: txt = {txt, 8'($urandom_range(0, 255))};
            endcase
            foreach (txt[i])
                send_byte(txt[i], $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_tokens();
        test_words_and_comments();
        test_strings();
        test_errors();
        test_stream_end();
        test_random_tokens(270);

        // final stretch with no idling on either side
        calm = 1'b1;
        test_random_tokens(70);
        send_byte(CH_SPACE, 1'b1);
        push <= 1'b0;

        while (token_stream_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
